// File: rtl/core/sorted_table_binary_search_assert.svh
// Assertion macros for the sorted table search block.
// Used by the port-level checker; no other dependencies.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// implication checked on the next edge, masked during reset
`define STS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sts check failed");

// same-edge implication, masked during reset
`define STS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sts check failed");

// reset behaviour, never masked
`define STS_ASSERT_RST(label, cons) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("sts reset check failed");

`endif

// File: rtl/core/sts_pkg.sv
// Shared types and constants for the sorted table search block.
// No dependencies.
package sts_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 32;
    localparam int CNT_W       = 5;
    localparam int IDX_W       = 4;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [KEY_W-1:0]  t_key;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_EMPTY
    } t_state;

    typedef struct packed {
        logic  we;
        logic  re;
        t_addr addr;
        t_key  wdata;
    } t_ram_req;

endpackage

// File: rtl/core/sts_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on sts_pkg.
interface sts_req_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [sts_pkg::IDX_W-1:0]      entry_index;
    logic signed [sts_pkg::KEY_W-1:0] key_value;

    modport source (output valid, command, entry_index, key_value, input ready);
    modport sink   (input valid, command, entry_index, key_value, output ready);
endinterface

interface sts_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [sts_pkg::IDX_W-1:0]  position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

// File: rtl/core/sts_ram.sv
// Key table: single-port synchronous RAM, registered read data.
// Depends on sts_pkg.
module sts_ram (
    input  logic              i_clk,
    input  sts_pkg::t_ram_req i_req,
    output sts_pkg::t_key     o_rdata
);

    sts_pkg::t_key mem [sts_pkg::TABLE_DEPTH];
    sts_pkg::t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sts_ctrl.sv
// Search sequencer with result register: one probe per cycle against the key RAM while that register is not blocked.
// Depends on sts_pkg and the channel interfaces.
module sts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sts_req_if.sink           i_req,
    sts_rsp_if.source         o_rsp,
    input  sts_pkg::t_cnt     i_entry_count,
    output sts_pkg::t_ram_req o_ram,
    input  sts_pkg::t_key     i_rdata
);

    sts_pkg::t_state r_state, n_state;
    sts_pkg::t_cnt   r_lo, n_lo;
    sts_pkg::t_cnt   r_hi1, n_hi1;
    sts_pkg::t_addr  r_mid, n_mid;
    logic signed [sts_pkg::KEY_W-1:0] r_key, n_key;
    logic            r_out_valid, n_out_valid;
    logic            r_found, n_found;
    sts_pkg::t_addr  r_pos, n_pos;

    sts_pkg::t_cnt   count_sat;
    logic            out_busy;
    logic            hit;
    logic            probe_less;
    logic            accept;

    // midpoint of [lo, hi1)
    function automatic sts_pkg::t_addr f_mid(input sts_pkg::t_cnt lo,
                                             input sts_pkg::t_cnt hi1);
        sts_pkg::t_cnt span;
        sts_pkg::t_cnt m;
        span = hi1 - lo - sts_pkg::CNT_W'(1);
        m    = lo + (span >> 1);
        return m[sts_pkg::ADDR_W-1:0];
    endfunction

    assign count_sat  = (i_entry_count > sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH)) ?
                        sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH) : i_entry_count;
    assign out_busy   = r_out_valid && !o_rsp.ready;
    assign hit        = (i_rdata == r_key);
    assign probe_less = ($signed(i_rdata) < r_key);
    assign accept     = i_req.valid && (r_state == sts_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sts_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_lo    <= n_lo;
        r_hi1   <= n_hi1;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi1       = r_hi1;
        n_mid       = r_mid;
        n_key       = r_key;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_found     = r_found;
        n_pos       = r_pos;
        o_ram.we    = 1'b0;
        o_ram.re    = 1'b0;
        o_ram.addr  = i_req.entry_index[sts_pkg::ADDR_W-1:0];
        o_ram.wdata = i_req.key_value;
        i_req.ready = 1'b0;

        case (r_state)
            sts_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (accept) begin
                    if (i_req.command == sts_pkg::CMD_WRITE) begin
                        o_ram.we = 1'b1;
                    end else begin
                        n_key = i_req.key_value;
                        n_lo  = '0;
                        n_hi1 = count_sat;
                        if (count_sat == '0) begin
                            n_state = sts_pkg::S_EMPTY;
                        end else begin
                            n_mid      = f_mid('0, count_sat);
                            o_ram.re   = 1'b1;
                            o_ram.addr = n_mid;
                            n_state    = sts_pkg::S_PROBE;
                        end
                    end
                end
            end
            sts_pkg::S_PROBE: begin
                // read data holds while the result register is blocked
                if (!out_busy) begin
                    if (hit) begin
                        n_out_valid = 1'b1;
                        n_found     = 1'b1;
                        n_pos       = r_mid;
                        n_state     = sts_pkg::S_IDLE;
                    end else begin
                        if (probe_less) begin
                            n_lo = {1'b0, r_mid} + sts_pkg::CNT_W'(1);
                        end else begin
                            n_hi1 = {1'b0, r_mid};
                        end
                        if (n_lo < n_hi1) begin
                            n_mid      = f_mid(n_lo, n_hi1);
                            o_ram.re   = 1'b1;
                            o_ram.addr = n_mid;
                        end else begin
                            n_out_valid = 1'b1;
                            n_found     = 1'b0;
                            n_pos       = '0;
                            n_state     = sts_pkg::S_IDLE;
                        end
                    end
                end
            end
            sts_pkg::S_EMPTY: begin
                if (!out_busy) begin
                    n_out_valid = 1'b1;
                    n_found     = 1'b0;
                    n_pos       = '0;
                    n_state     = sts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sts_pkg::S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.found    = r_found;
    assign o_rsp.position = r_pos;

endmodule

// File: rtl/core/sorted_table_binary_search.sv
// Write transaction: no response. Search transaction: one probe per cycle, while the
// response register is not blocked, through the single-port key RAM, 0 to 5 probes
// (none for an empty table); response registered after the last probe.
// The response register lets the next transaction in while a result waits.
// Reset (synchronous, active low) clears control and entry_count; table undefined.
module sorted_table_binary_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sts_req_if.sink                    i_req,
    sts_rsp_if.source                  o_rsp,
    input  logic                       i_cfg_we,
    input  logic [sts_pkg::CNT_W-1:0]  i_cfg_data
);

    sts_pkg::t_cnt     r_entry_count;
    sts_pkg::t_ram_req ram_req;
    sts_pkg::t_key     ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_data;
        end
    end

    sts_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .i_entry_count (r_entry_count),
        .o_ram         (ram_req),
        .i_rdata       (ram_rdata)
    );

    sts_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule

// File: rtl/core/sts_chk.sv
// Port-level checker for the sorted table search block, bound to the top level.
// Depends on sorted_table_binary_search_assert.svh.
`include "sorted_table_binary_search_assert.svh"

module sts_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic                       i_found,
    input logic [sts_pkg::IDX_W-1:0]  i_position
);

    `STS_ASSERT_RST(a_rst_no_rsp, !i_rsp_valid)
    `STS_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_found) && $stable(i_position))
    `STS_ASSERT_NOW(a_miss_pos_zero, i_rsp_valid && !i_found, i_position == '0)
    `STS_ASSERT_NEXT(a_no_instant_rsp, i_req_valid && i_req_ready && (!i_rsp_valid || i_rsp_ready), !i_rsp_valid)

endmodule

bind sorted_table_binary_search sts_chk u_sts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_found     (o_rsp.found),
    .i_position  (o_rsp.position)
);
